FILE: rtl/psel_pkg.sv
package psel_pkg;

  // Default number of list cells.
  localparam int LIST_DEPTH_DEF = 16;

  // Field widths of a request and of a result.
  localparam int PRIO_W  = 14;
  localparam int TYPE_W  = 4;
  localparam int KIND_W  = 8;
  localparam int CTRL_W  = 8;
  localparam int DATA_W  = 32;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  // Reset value of the drive order type limit.
  localparam logic [TYPE_W-1:0] LIMIT_RST = 4'd3;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_READ    = 2'd1,
    CMD_PROMOTE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STS_DONE  = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    cmd_t              command;
    logic [TYPE_W-1:0] entry_type;
    logic [PRIO_W-1:0] priority_req;
    logic [DATA_W-1:0] payload;
    logic [KIND_W-1:0] drive_kind;
    logic [CTRL_W-1:0] controller_id;
    logic [POS_W-1:0]  position;
  } in_req_t;

  typedef struct packed {
    status_t            status;
    logic [TYPE_W-1:0]  out_type;
    logic [PRIO_W-1:0]  out_priority;
    logic [DATA_W-1:0]  out_payload;
    logic [COUNT_W-1:0] entry_count;
  } out_rsp_t;

  // One held entry: the sort key and its data word.
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TYPE_W-1:0] etype;
    logic [KIND_W-1:0] kind;
    logic [CTRL_W-1:0] ctrl;
    logic [DATA_W-1:0] data;
  } entry_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic              do_ins;
    logic              do_prm;
    logic [TYPE_W-1:0] limit;
    entry_t            new_entry;
  } cell_ctl_t;

  // True when entry a sorts strictly before entry b.
  function automatic logic key_less(entry_t a, entry_t b, logic [TYPE_W-1:0] limit);
    logic res;
    if (a.prio != b.prio) begin
      res = a.prio < b.prio;
    end else if (a.etype != b.etype) begin
      res = a.etype < b.etype;
    end else if (a.etype <= limit) begin
      res = {a.kind, a.ctrl} < {b.kind, b.ctrl};
    end else begin
      res = 1'b0;
    end
    return res;
  endfunction

endpackage

FILE: rtl/psel_cell.sv
module psel_cell
  import psel_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CNT_W-1:0] count,
  input  logic [POS_W-1:0] pos,
  input  entry_t           left_entry,
  input  logic             found_in,
  output entry_t           entry_q,
  output logic             found_out
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   occupied;
  logic   new_before;
  logic   at_end;

  assign occupied   = 32'(INDEX) < 32'(count);
  assign at_end     = 32'(INDEX) == 32'(count);
  assign new_before = occupied && key_less(ctl.new_entry, entry_r, ctl.limit);

  // The found flag ripples toward the tail: set once some cell ahead sorts after the new entry.
  assign found_out = found_in | new_before;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.do_ins) begin
      if (found_in && (32'(INDEX) <= 32'(count))) begin
        entry_nxt = left_entry;
      end else if (!found_in && (new_before || at_end)) begin
        entry_nxt = ctl.new_entry;
      end
    end else if (ctl.do_prm) begin
      if (32'(INDEX) <= 32'(pos)) begin
        entry_nxt = left_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule

FILE: rtl/priority_sorted_entry_list_unit.sv
// A request accepted while idle is registered and moves the sequencer to its execute state;
// the result register then loads and raises out_valid. No new request is taken while busy,
// which is high for the single execute cycle, in which every cell of the list compares,
// shifts or loads in parallel.
// Reset: rst_n is synchronous and active low; it empties the list and loads the limit with 3.
// The receiver cannot stall; each result is shown for exactly one cycle.
module priority_sorted_entry_list_unit
  import psel_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_req_t           in_req,
  output logic              out_valid,
  output out_rsp_t          out_rsp,
  input  logic              cfg_we,
  input  logic [TYPE_W-1:0] cfg_wdata
);

  // The held count must reach the depth itself; a cell index only needs the depth.
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  state_t            state_r;
  state_t            state_nxt;
  in_req_t           req_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [TYPE_W-1:0] limit_r;
  logic              out_valid_r;
  out_rsp_t          out_rsp_r;
  out_rsp_t          rsp_nxt;
  logic              accept;
  logic              exec;
  logic              full;
  logic              pos_ok;
  cell_ctl_t         ctl;
  entry_t            sel_entry;
  entry_t            prm_entry;

  entry_t cell_q     [LIST_DEPTH];
  entry_t cell_left  [LIST_DEPTH];
  logic   found      [LIST_DEPTH+1];

  // A request is taken only while no other one is in execution.
  assign accept = start && !busy;

  // Next-state logic of the two-state sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    busy = 1'b0;
    exec = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        exec = 1'b0;
      end
      ST_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
        exec = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The request is held for its execute cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
  end

  // The limit only affects comparisons of later inserts; held entries are never re-sorted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  assign full   = count_r == CNT_W'(LIST_DEPTH);
  assign pos_ok = (32'(req_r.position) < 32'(count_r)) &&
                  (32'(req_r.position) < 32'(LIST_DEPTH));

  // The entry at the requested position, and its promoted copy with priority zero.
  always_comb begin
    sel_entry      = cell_q[IDX_W'(req_r.position)];
    prm_entry      = sel_entry;
    prm_entry.prio = '0;
  end

  // Command decode: what the cells do and what the result carries.
  always_comb begin
    ctl.do_ins              = 1'b0;
    ctl.do_prm              = 1'b0;
    ctl.limit               = limit_r;
    ctl.new_entry.prio      = req_r.priority_req;
    ctl.new_entry.etype     = req_r.entry_type;
    ctl.new_entry.kind      = req_r.drive_kind;
    ctl.new_entry.ctrl      = req_r.controller_id;
    ctl.new_entry.data      = req_r.payload;
    count_nxt               = count_r;
    rsp_nxt.status          = STS_DONE;
    rsp_nxt.out_type        = '0;
    rsp_nxt.out_priority    = '0;
    rsp_nxt.out_payload     = '0;
    unique case (req_r.command)
      CMD_INSERT: begin
        if (full) begin
          rsp_nxt.status = STS_FULL;
        end else begin
          ctl.do_ins = exec;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (pos_ok) begin
          rsp_nxt.out_type     = sel_entry.etype;
          rsp_nxt.out_priority = sel_entry.prio;
          rsp_nxt.out_payload  = sel_entry.data;
        end else begin
          rsp_nxt.status = STS_EMPTY;
        end
      end
      CMD_PROMOTE: begin
        if (pos_ok) begin
          ctl.do_prm           = exec;
          rsp_nxt.out_type     = sel_entry.etype;
          rsp_nxt.out_payload  = sel_entry.data;
        end else begin
          rsp_nxt.status = STS_EMPTY;
        end
      end
      default: begin
        // The unused command code changes nothing and reports done.
        rsp_nxt.status = STS_DONE;
      end
    endcase
    rsp_nxt.entry_count = COUNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (exec) begin
      count_r <= count_nxt;
    end
  end

  // Result register: the strobe lasts one cycle and the receiver cannot refuse it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // The chain of cells. Each cell takes its left neighbor's entry on a shift; the head cell's
  // left neighbor is the promoted entry, which is only used on a promote.
  assign found[0] = 1'b0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_left[i] = prm_entry;
    end else begin : g_body
      assign cell_left[i] = cell_q[i-1];
    end

    psel_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .pos        (req_r.position),
      .left_entry (cell_left[i]),
      .found_in   (found[i]),
      .entry_q    (cell_q[i]),
      .found_out  (found[i+1])
    );
  end

`ifndef SYNTHESIS
  // The list never holds more entries than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(LIST_DEPTH))
    else $error("held count exceeds list depth");

  // The execute state lasts exactly one cycle.
  a_exec_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |=> (state_r == ST_IDLE))
    else $error("execute state held longer than one cycle");

  // A result strobe follows an execute cycle.
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(exec))
    else $error("result strobe without an executed request");

  // A dropped insert is reported only for a full list.
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_rsp_r.status == STS_FULL)) |-> full)
    else $error("insert dropped while the list had room");

  // The held count only ever grows by one.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |-> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("held count changed by other than one");
`endif

endmodule

FILE: sim/psel_list_checker.sv
`timescale 1ns / 1ps

module psel_list_checker
  import psel_pkg::*;
#(
  parameter int DEPTH = LIST_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  in_req_t           in_req,
  input  logic              out_valid,
  input  out_rsp_t          out_rsp,
  input  logic              cfg_we,
  input  logic [TYPE_W-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending,
  output int                replies_checked,
  output int                dropped_inserts,
  output int                promotes_done,
  output int                empty_hits
);

  localparam int RANK_W    = PRIO_W + TYPE_W + KIND_W + CTRL_W;
  localparam int MAX_PRINT = 40;

  entry_t            held [DEPTH];
  int                held_n;
  logic [TYPE_W-1:0] tie_limit;
  out_rsp_t          reply_q [$];

  // Drive kind and controller id only count for type codes at or below the limit.
  function automatic logic [RANK_W-1:0] rank(entry_t e);
    return {e.prio, e.etype, (e.etype <= tie_limit) ? {e.kind, e.ctrl} : 16'h0};
  endfunction

  function automatic out_rsp_t update_list(in_req_t r);
    out_rsp_t rsp;
    entry_t   fresh;
    entry_t   moved;
    int       slot;
    rsp = '0;
    rsp.status = STS_DONE;
    case (r.command)
      CMD_INSERT: begin
        if (held_n >= DEPTH) begin
          rsp.status = STS_FULL;
          dropped_inserts++;
        end else begin
          fresh.prio  = r.priority_req;
          fresh.etype = r.entry_type;
          fresh.kind  = r.drive_kind;
          fresh.ctrl  = r.controller_id;
          fresh.data  = r.payload;
          slot = 0;
          while (slot < held_n && !(rank(fresh) < rank(held[slot]))) slot++;
          for (int i = held_n; i > slot; i--) held[i] = held[i-1];
          held[slot] = fresh;
          held_n++;
        end
      end
      CMD_READ, CMD_PROMOTE: begin
        if (r.position >= held_n) begin
          rsp.status = STS_EMPTY;
          empty_hits++;
        end else begin
          moved = held[r.position];
          if (r.command == CMD_PROMOTE) begin
            for (int i = r.position; i > 0; i--) held[i] = held[i-1];
            moved.prio = '0;
            held[0] = moved;
            promotes_done++;
          end
          rsp.out_type     = moved.etype;
          rsp.out_priority = moved.prio;
          rsp.out_payload  = moved.data;
        end
      end
      default: ;
    endcase
    rsp.entry_count = COUNT_W'(held_n);
    return rsp;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (fail_count < MAX_PRINT) begin
      $display("%0t mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    end
    fail_count++;
  endtask

  task automatic check_reply(input out_rsp_t got);
    out_rsp_t want;
    if (reply_q.size() == 0) begin
      report("reply with no request outstanding, status", got.status, 0);
    end else begin
      want = reply_q.pop_front();
      replies_checked++;
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.out_type !== want.out_type) report("out_type", got.out_type, want.out_type);
      if (got.out_priority !== want.out_priority) begin
        report("out_priority", got.out_priority, want.out_priority);
      end
      if (got.out_payload !== want.out_payload) begin
        report("out_payload", got.out_payload, want.out_payload);
      end
      if (got.entry_count !== want.entry_count) begin
        report("entry_count", got.entry_count, want.entry_count);
      end
    end
  endtask

  initial begin
    fail_count      = 0;
    pending         = 0;
    replies_checked = 0;
    dropped_inserts = 0;
    promotes_done   = 0;
    empty_hits      = 0;
    held_n          = 0;
    tie_limit       = LIMIT_RST;
    for (int i = 0; i < DEPTH; i++) held[i] = '0;
  end

  // Replies are checked before the new request is applied; a reply at this edge always
  // belongs to a request taken at an earlier edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      held_n    = 0;
      tie_limit = LIMIT_RST;
      reply_q.delete();
    end else begin
      if (out_valid === 1'b1) check_reply(out_rsp);
      if (cfg_we) tie_limit = cfg_wdata;
      if (start && busy === 1'b0) reply_q.push_back(update_list(in_req));
    end
    pending = reply_q.size();
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import psel_pkg::*;

  // The package names commands 0 to 2 only; code 3 must be a no-op with status done.
  localparam cmd_t CMD_UNUSED     = cmd_t'(2'd3);
  localparam int   WATCHDOG_LIMIT = 1000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_req_t           in_req;
  logic              out_valid;
  out_rsp_t          out_rsp;
  logic              cfg_we;
  logic [TYPE_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int replies_checked;
  int dropped_inserts;
  int promotes_done;
  int empty_hits;

  // Stimulus-side bookkeeping: current tie limit (to aim inserts at the tie-break
  // boundary), how many inserts have landed so far, and how many requests went out.
  logic [TYPE_W-1:0] cur_limit;
  int                list_fill;
  int                requests_sent;

  priority_sorted_entry_list_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  psel_list_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req          (in_req),
    .out_valid       (out_valid),
    .out_rsp         (out_rsp),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .replies_checked (replies_checked),
    .dropped_inserts (dropped_inserts),
    .promotes_done   (promotes_done),
    .empty_hits      (empty_hits)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a correct run never goes this long without taking a request or a reply.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && busy === 1'b0) || out_valid === 1'b1) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: no request or reply for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // An insert request. The position field is unused by an insert but still gets random
  // bits so that every input bit toggles.
  function automatic in_req_t make_insert(input logic [PRIO_W-1:0] prio,
                                          input logic [TYPE_W-1:0] etype,
                                          input logic [KIND_W-1:0] kind,
                                          input logic [CTRL_W-1:0] ctrl,
                                          input logic [DATA_W-1:0] data);
    in_req_t r;
    r.command       = CMD_INSERT;
    r.entry_type    = etype;
    r.priority_req  = prio;
    r.payload       = data;
    r.drive_kind    = kind;
    r.controller_id = ctrl;
    r.position      = POS_W'($urandom);
    return r;
  endfunction

  // A read, promote or unused-code request; the key and payload fields carry noise.
  function automatic in_req_t make_pick(input cmd_t cmd, input logic [POS_W-1:0] pos);
    in_req_t r;
    r.command       = cmd;
    r.entry_type    = TYPE_W'($urandom);
    r.priority_req  = PRIO_W'($urandom);
    r.payload       = $urandom;
    r.drive_kind    = KIND_W'($urandom);
    r.controller_id = CTRL_W'($urandom);
    r.position      = pos;
    return r;
  endfunction

  // Random insert biased toward ties: small or maximal priorities, type codes right at
  // and just above the current limit, and clustered drive kind / controller id values.
  function automatic in_req_t random_insert();
    logic [PRIO_W-1:0] prio;
    logic [TYPE_W-1:0] etype;
    logic [KIND_W-1:0] kind;
    logic [CTRL_W-1:0] ctrl;
    int                sel;
    sel = $urandom_range(99);
    if (sel < 40) begin
      prio = PRIO_W'($urandom_range(2));
    end else if (sel < 50) begin
      prio = '1;
    end else begin
      prio = PRIO_W'($urandom);
    end
    sel = $urandom_range(99);
    if (sel < 25) begin
      etype = cur_limit;
    end else if (sel < 45) begin
      etype = cur_limit + 1'b1;
    end else begin
      etype = TYPE_W'($urandom);
    end
    if ($urandom_range(1) == 0) begin
      kind = KIND_W'($urandom_range(1));
      ctrl = CTRL_W'($urandom_range(1));
    end else begin
      kind = KIND_W'($urandom);
      ctrl = CTRL_W'($urandom);
    end
    return make_insert(prio, etype, kind, ctrl, $urandom);
  endfunction

  // Present one request and hold it until it is taken. start is left high after the
  // handshake so that back-to-back requests never lower and raise it in the same step;
  // it only drops when the sender chooses to idle or a sequence ends.
  task automatic issue(input in_req_t r, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    requests_sent++;
    if (r.command == CMD_INSERT && list_fill < LIST_DEPTH_DEF) list_fill++;
  endtask

  // Wait until every outstanding request has produced its reply, then let the pipeline
  // settle. The pending count is read on the falling edge, clear of the checker's update.
  task automatic drain();
    do @(negedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  // The limit register may only change while the block is idle.
  task automatic set_limit(input logic [TYPE_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    cur_limit  = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random phase. Inserts are held back once the list reaches fill_cap so that the
  // sixteen slots fill across several limit settings; once the list is full, inserts
  // come back to exercise the dropped-insert path.
  task automatic run_phase(input int n_req, input int idle_pct, input int fill_cap);
    int      pick;
    in_req_t r;
    for (int k = 0; k < n_req; k++) begin
      pick = $urandom_range(99);
      if (pick < 30 && (list_fill < fill_cap || list_fill == LIST_DEPTH_DEF)) begin
        r = random_insert();
      end else if (pick < 62) begin
        r = make_pick(CMD_READ, POS_W'($urandom));
      end else if (pick < 94) begin
        r = make_pick(CMD_PROMOTE, POS_W'($urandom));
      end else begin
        r = make_pick(CMD_UNUSED, POS_W'($urandom));
      end
      issue(r, idle_pct);
    end
    start <= 1'b0;
  endtask

  task automatic run_directed();
    // Empty list: read and promote both report an empty position; code 3 does nothing.
    issue(make_pick(CMD_READ, 4'd0), 21);
    issue(make_pick(CMD_PROMOTE, 4'd15), 21);
    issue(make_pick(CMD_UNUSED, 4'd0), 21);
    // Same priority, type 3 sits at the reset limit, so drive kind and then controller
    // id decide the order; an exact duplicate key lands behind the earlier one.
    issue(make_insert(14'd5, 4'd3, 8'd2, 8'd1, 32'h1111_0001), 21);
    issue(make_insert(14'd5, 4'd3, 8'd1, 8'd9, 32'h1111_0002), 21);
    issue(make_insert(14'd5, 4'd3, 8'd1, 8'd9, 32'h1111_0003), 21);
    // Type 4 is above the limit: drive kind and controller id are ignored and these
    // three keep arrival order even though the middle one has the largest low bits.
    issue(make_insert(14'd5, 4'd4, 8'd0, 8'd0, 32'h2222_0001), 21);
    issue(make_insert(14'd5, 4'd4, 8'd255, 8'd255, 32'h2222_0002), 21);
    issue(make_insert(14'd5, 4'd4, 8'd0, 8'd0, 32'h2222_0003), 21);
    // Field extremes: the largest key goes to the back, the all-zero key to the front.
    issue(make_insert('1, '1, '1, '1, '1), 21);
    issue(make_insert('0, '0, '0, '0, '0), 21);
    // Controller id alone breaks the tie against the earlier type 3 entries of drive kind 1.
    issue(make_insert(14'd5, 4'd3, 8'd1, 8'd8, 32'h1111_0004), 21);
    // Walk the whole list, then one position just past the end and the last position.
    for (int p = 0; p < 9; p++) issue(make_pick(CMD_READ, POS_W'(p)), 21);
    issue(make_pick(CMD_READ, 4'd9), 21);
    issue(make_pick(CMD_READ, 4'd15), 21);
    // Promote the tail entry and one from the middle, then look at the new front.
    issue(make_pick(CMD_PROMOTE, 4'd8), 21);
    issue(make_pick(CMD_PROMOTE, 4'd4), 21);
    issue(make_pick(CMD_READ, 4'd0), 21);
    start <= 1'b0;
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_req        = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    cur_limit     = LIMIT_RST;
    list_fill     = 0;
    requests_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed checks run at the reset limit.
    run_directed();

    // Top limit: every type code breaks ties on drive kind and controller id.
    set_limit(4'd15);
    run_phase(310, 21, 12);

    // Bottom limit: only type 0 uses the extra tie-breakers; the list fills here.
    set_limit(4'd0);
    run_phase(310, 73, LIST_DEPTH_DEF);

    // Some value in between, with the sender never idling.
    set_limit(TYPE_W'($urandom_range(14, 1)));
    run_phase(310, 0, LIST_DEPTH_DEF);

    drain();
    @(negedge clk);
    $display("Sent %0d requests and checked %0d replies over tie limits 3, 15, 0 and %0d.",
             requests_sent, replies_checked, cur_limit);
    $display("Replies included %0d dropped inserts, %0d promotes, %0d empty positions.",
             dropped_inserts, promotes_done, empty_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/psel_pkg.sv
rtl/psel_cell.sv
rtl/priority_sorted_entry_list_unit.sv
sim/psel_list_checker.sv
sim/tb_top.sv
